// ----- hdl/brb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int DEPTH     = 1024;
  localparam int AW        = $clog2(DEPTH);
  localparam int CAPW      = AW + 1;
  localparam int MAX_CHUNK = 64;
  localparam int LENW      = 7;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [CAPW-1:0] CAP_RESET = CAPW'(DEPTH);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [1:0] OP_STORE      = 2'd0;
  localparam logic [1:0] OP_STORE_RESP = 2'd1;
  localparam logic [1:0] OP_RESP       = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [AW-1:0]   addr;
    logic [7:0]      data;
    logic [LENW-1:0] len;
    logic            ok;
    logic            kind;
  } cmd_t;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos,
                                             input logic [CAPW-1:0] cap);
    logic [CAPW-1:0] inc;
    inc = {1'b0, pos} + CAPW'(1);
    next_pos = (inc >= cap) ? '0 : inc[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/brb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brb_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [6:0] chunk_bytes;
  logic [7:0] write_byte;

  modport source (output valid, req_type, chunk_bytes, write_byte, input ready);
  modport sink (input valid, req_type, chunk_bytes, write_byte, output ready);
endinterface

interface brb_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       resp_kind;
  logic [7:0] read_byte;
  logic       last;

  modport source (output valid, ok, resp_kind, read_byte, last, input ready);
  modport sink (input valid, ok, resp_kind, read_byte, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/brb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [brb_pkg::CAPW-1:0]  cap,
  input  wire logic                      clr,
  brb_in_if.sink                         in_ch,
  input  wire logic                      q_full,
  output logic                           q_push,
  output brb_pkg::cmd_t                  q_cmd
);

  logic [brb_pkg::AW-1:0]   rd_pos_r, rd_pos_nxt;
  logic [brb_pkg::AW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [brb_pkg::CAPW-1:0] used_r, used_nxt;
  logic [brb_pkg::LENW-1:0] left_r, left_nxt;
  logic                     acc_r, acc_nxt;

  logic                     accept;
  logic [brb_pkg::LENW-1:0] len;
  logic                     len_ok;
  logic [brb_pkg::CAPW-1:0] free_bytes;
  logic                     first;
  logic                     acc;
  logic [brb_pkg::LENW-1:0] left;
  logic [brb_pkg::LENW-1:0] left_n;
  logic                     store;
  logic                     rd_fail;
  logic [brb_pkg::CAPW-1:0] rd_sum;
  logic [brb_pkg::CAPW-1:0] rd_wrap;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign len         = in_ch.chunk_bytes;
  assign len_ok      = (len != '0) && (len <= brb_pkg::LENW'(brb_pkg::MAX_CHUNK));
  assign free_bytes  = (used_r < cap) ? (cap - used_r) : '0;
  assign first       = (left_r == '0);
  assign acc         = first ? (len_ok && (brb_pkg::CAPW'(len) <= free_bytes)) : acc_r;
  assign left        = first ? ((len == '0) ? brb_pkg::LENW'(1) : len) : left_r;
  assign left_n      = left - brb_pkg::LENW'(1);
  assign store       = acc && (used_r < cap);
  assign rd_fail     = !len_ok || (brb_pkg::CAPW'(len) > used_r);
  assign rd_sum      = {1'b0, rd_pos_r} + brb_pkg::CAPW'(len);
  assign rd_wrap     = (rd_sum >= cap) ? (rd_sum - cap) : rd_sum;

  always_comb begin
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    used_nxt   = used_r;
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    q_push     = 1'b0;
    q_cmd.op   = brb_pkg::OP_RESP;
    q_cmd.addr = wr_pos_r;
    q_cmd.data = in_ch.write_byte;
    q_cmd.len  = len;
    q_cmd.ok   = 1'b0;
    q_cmd.kind = brb_pkg::KIND_WRITE;
    if (accept) begin
      if (in_ch.req_type == brb_pkg::REQ_WRITE) begin
        left_nxt = left_n;
        acc_nxt  = (left_n == '0) ? 1'b0 : acc;
        q_cmd.ok = acc;
        if (store) begin
          wr_pos_nxt = brb_pkg::next_pos(wr_pos_r, cap);
          used_nxt   = used_r + brb_pkg::CAPW'(1);
        end
        if (store && left_n == '0) begin
          q_push   = 1'b1;
          q_cmd.op = brb_pkg::OP_STORE_RESP;
        end else if (store) begin
          q_push   = 1'b1;
          q_cmd.op = brb_pkg::OP_STORE;
        end else if (left_n == '0) begin
          q_push   = 1'b1;
          q_cmd.op = brb_pkg::OP_RESP;
        end
      end else begin
        q_push     = 1'b1;
        q_cmd.kind = brb_pkg::KIND_READ;
        if (rd_fail) begin
          q_cmd.op = brb_pkg::OP_RESP;
          q_cmd.ok = 1'b0;
        end else begin
          q_cmd.op   = brb_pkg::OP_READ;
          q_cmd.addr = rd_pos_r;
          q_cmd.ok   = 1'b1;
          rd_pos_nxt = rd_wrap[brb_pkg::AW-1:0];
          used_nxt   = used_r - brb_pkg::CAPW'(len);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      rd_pos_r <= '0;
      wr_pos_r <= '0;
      used_r   <= '0;
      left_r   <= '0;
      acc_r    <= 1'b0;
    end else begin
      rd_pos_r <= rd_pos_nxt;
      wr_pos_r <= wr_pos_nxt;
      used_r   <= used_nxt;
      left_r   <= left_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/brb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brb_pkg::cmd_t wdata,
  input  wire logic          pop,
  output brb_pkg::cmd_t      rdata,
  output logic               full,
  output logic               empty
);

  brb_pkg::cmd_t           q_r [brb_pkg::QDEPTH];
  logic [brb_pkg::QAW-1:0] wp_r, wp_nxt;
  logic [brb_pkg::QAW-1:0] rp_r, rp_nxt;
  logic [brb_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (brb_pkg::QAW+1)'(brb_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + brb_pkg::QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + brb_pkg::QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (brb_pkg::QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (brb_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/brb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [brb_pkg::CAPW-1:0]  cap,
  input  wire logic                      q_empty,
  input  wire brb_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  brb_out_if.source                      out_ch
);

  logic [7:0]               mem [brb_pkg::DEPTH];
  logic [7:0]               rd_data_r;
  logic [brb_pkg::AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [brb_pkg::LENW-1:0] rd_left_r, rd_left_nxt;

  logic pend_r, pend_nxt;
  logic pend_mem_r, pend_mem_nxt;
  logic pend_ok_r, pend_ok_nxt;
  logic pend_kind_r, pend_kind_nxt;
  logic pend_last_r, pend_last_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r, out_ok_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic out_free;
  logic can_issue;
  logic reading;
  logic need_emit;
  logic rd_issue;
  logic st_issue;
  logic mem_we;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign can_issue = !pend_r || out_free;
  assign reading   = (rd_left_r != '0);
  assign need_emit = (q_cmd.op == brb_pkg::OP_STORE_RESP) || (q_cmd.op == brb_pkg::OP_RESP);
  assign q_pop     = !q_empty && !reading && (!need_emit || can_issue);
  assign rd_issue  = reading && can_issue;
  assign st_issue  = q_pop && need_emit;
  assign mem_we    = q_pop && ((q_cmd.op == brb_pkg::OP_STORE) ||
                               (q_cmd.op == brb_pkg::OP_STORE_RESP));

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.resp_kind = out_kind_r;
  assign out_ch.read_byte = out_byte_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    rd_addr_nxt = rd_addr_r;
    rd_left_nxt = rd_left_r;
    if (q_pop && q_cmd.op == brb_pkg::OP_READ) begin
      rd_addr_nxt = q_cmd.addr;
      rd_left_nxt = q_cmd.len;
    end else if (rd_issue) begin
      rd_addr_nxt = brb_pkg::next_pos(rd_addr_r, cap);
      rd_left_nxt = rd_left_r - brb_pkg::LENW'(1);
    end

    pend_nxt      = pend_r;
    pend_mem_nxt  = pend_mem_r;
    pend_ok_nxt   = pend_ok_r;
    pend_kind_nxt = pend_kind_r;
    pend_last_nxt = pend_last_r;
    if (rd_issue) begin
      pend_nxt      = 1'b1;
      pend_mem_nxt  = 1'b1;
      pend_ok_nxt   = 1'b1;
      pend_kind_nxt = brb_pkg::KIND_READ;
      pend_last_nxt = (rd_left_r == brb_pkg::LENW'(1));
    end else if (st_issue) begin
      pend_nxt      = 1'b1;
      pend_mem_nxt  = 1'b0;
      pend_ok_nxt   = q_cmd.ok;
      pend_kind_nxt = q_cmd.kind;
      pend_last_nxt = 1'b1;
    end else if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = pend_ok_r;
      out_kind_nxt  = pend_kind_r;
      out_byte_nxt  = pend_mem_r ? rd_data_r : 8'd0;
      out_last_nxt  = pend_last_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.addr] <= q_cmd.data;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    pend_mem_r  <= pend_mem_nxt;
    pend_ok_r   <= pend_ok_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_last_r <= pend_last_nxt;
    out_ok_r    <= out_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    rd_addr_r   <= rd_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_left_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_left_r   <= rd_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/byte_ring_buffer_chunked.sv -----
// Circular byte store with all-or-nothing chunk writes and reads. A write word carries one
// byte of a chunk and is taken every cycle while the four-entry command queue has room; the
// verdict on a chunk is made at its first byte and one status word follows its last byte. A
// read request is dispatched from the queue by the back end, which then emits one byte per
// cycle from the single-port byte memory while the output accepts them, taking no other
// command until the read is done; a failed read or a write status is a single word. Writing
// the capacity register empties the ring; do so only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_chunked (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [brb_pkg::CAPW-1:0] cfg_wdata,
  brb_in_if.sink                        in_ch,
  brb_out_if.source                     out_ch
);

  logic [brb_pkg::CAPW-1:0] cap_r;
  logic [brb_pkg::CAPW-1:0] cap_eff;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  brb_pkg::cmd_t            push_cmd;
  brb_pkg::cmd_t            head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= brb_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_eff = (cap_r == '0) ? brb_pkg::CAPW'(1) :
                   (cap_r > brb_pkg::CAP_RESET) ? brb_pkg::CAP_RESET : cap_r;

  brb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cap    (cap_eff),
    .clr    (cfg_we),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  brb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  brb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cap     (cap_eff),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("command popped from an empty queue");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (!out_ch.ok || out_ch.resp_kind == brb_pkg::KIND_WRITE))
      |-> (out_ch.last && out_ch.read_byte == 8'd0))
    else $error("status word is not a single zero-data word");

  a_read_ok_at_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_cmd.op == brb_pkg::OP_READ) |-> (head_cmd.len != '0))
    else $error("read command with zero length dispatched");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import brb_pkg::*;

  typedef struct packed {
    logic       ok;
    logic       kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  class ring_book;
    logic [7:0]  cells [DEPTH];
    int unsigned cap_reg;
    int unsigned rd_at;
    int unsigned wr_at;
    int unsigned held;
    int unsigned chunk_todo;
    bit          chunk_ok;
    reply_t      due_replies [$];
    int          errors;

    function new();
      cap_reg = DEPTH;
      errors  = 0;
      clear();
    endfunction

    function void clear();
      rd_at      = 0;
      wr_at      = 0;
      held       = 0;
      chunk_todo = 0;
      chunk_ok   = 1'b0;
    endfunction

    function int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function void set_capacity(logic [CAPW-1:0] v);
      cap_reg = v;
      clear();
    endfunction

    function int due();
      return due_replies.size();
    endfunction

    function void take_word(logic rt, logic [LENW-1:0] len, logic [7:0] b);
      int unsigned cap;
      reply_t      r;
      cap = eff_cap();
      if (rt == REQ_WRITE) begin
        if (chunk_todo == 0) begin
          chunk_ok   = (len >= 1) && (len <= MAX_CHUNK) && (held + len <= cap);
          chunk_todo = (len == 0) ? 1 : len;
        end
        if (chunk_ok && held < cap) begin
          cells[wr_at] = b;
          wr_at = (wr_at + 1) % cap;
          held++;
        end
        chunk_todo--;
        if (chunk_todo == 0) begin
          r = '{ok: chunk_ok, kind: KIND_WRITE, data: 8'h00, last: 1'b1};
          due_replies.push_back(r);
          chunk_ok = 1'b0;
        end
      end else if (len == 0 || len > MAX_CHUNK || len > held) begin
        r = '{ok: 1'b0, kind: KIND_READ, data: 8'h00, last: 1'b1};
        due_replies.push_back(r);
      end else begin
        for (int i = 0; i < len; i++) begin
          r = '{ok: 1'b1, kind: KIND_READ, data: cells[rd_at], last: (i + 1 == len)};
          rd_at = (rd_at + 1) % cap;
          due_replies.push_back(r);
        end
        held -= len;
      end
    endfunction

    function void match_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got ok=%0b kind=%0b byte=%02h last=%0b",
                 $time, got.ok, got.kind, got.data, got.last);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0b got %0b", $time, want.ok, got.ok);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: resp_kind expected %0b got %0b", $time, want.kind, got.kind);
        errors++;
      end
      if (got.data !== want.data) begin
        $display("%0t: read_byte expected %02h got %02h", $time, want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [CAPW-1:0] cfg_wdata;
  bit              calm;
  int              words_sent;
  ring_book        ring;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  byte_ring_buffer_chunked dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        ring.take_word(in_ch.req_type, in_ch.chunk_bytes, in_ch.write_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        ring.match_reply('{ok: out_ch.ok, kind: out_ch.resp_kind, data: out_ch.read_byte,
                           last: out_ch.last});
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic push_word(logic rt, logic [LENW-1:0] len, logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rt;
    in_ch.chunk_bytes <= len;
    in_ch.write_byte  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk(int len, int split);
    int bytes;
    int top;
    bytes = (len == 0) ? 1 : len;
    for (int i = 0; i < bytes; i++) begin
      if (i > 0 && i == split) begin
        top = (ring.held + 1 > MAX_CHUNK) ? MAX_CHUNK : ring.held + 1;
        push_word(REQ_READ, LENW'($urandom_range(1, top)), 8'($urandom_range(0, 255)));
      end
      push_word(REQ_WRITE, (i == 0) ? LENW'(len) : LENW'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (ring.due() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_cap(logic [CAPW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ring.set_capacity(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic churn(int words);
    int stop;
    int len;
    int room;
    int pick;
    int top;
    stop = words_sent + words;
    while (words_sent < stop) begin
      room = ring.eff_cap() - ring.held;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 20 && room >= 1 && room <= MAX_CHUNK) len = room;
        else if (pick < 27) len = 0;
        else if (pick < 35) len = $urandom_range(9, MAX_CHUNK);
        else len = $urandom_range(1, 8);
        send_chunk(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, len + 1) : 0);
      end else begin
        pick = $urandom_range(0, 99);
        top  = (ring.held + 2 > MAX_CHUNK) ? MAX_CHUNK : ring.held + 2;
        if (pick < 30 && ring.held >= 1 && ring.held <= MAX_CHUNK) len = ring.held;
        else if (pick < 40) len = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
        else len = $urandom_range(1, top);
        push_word(REQ_READ, LENW'(len), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    ring              = new();
    calm              = 1'b0;
    words_sent        = 0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_WRITE;
    in_ch.chunk_bytes = '0;
    in_ch.write_byte  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_word(REQ_READ, 7'd1, 8'h00);
    push_word(REQ_WRITE, 7'd1, 8'h00);
    push_word(REQ_WRITE, 7'd1, 8'hFF);
    push_word(REQ_WRITE, 7'd0, 8'h5A);
    push_word(REQ_READ, 7'd0, 8'hFF);
    push_word(REQ_READ, 7'd127, 8'h00);
    push_word(REQ_READ, 7'd3, 8'h00);
    push_word(REQ_READ, 7'd2, 8'h00);
    send_chunk(3, 1);
    push_word(REQ_READ, 7'd64, 8'h00);
    push_word(REQ_READ, 7'd3, 8'h00);

    quiesce();
    set_cap(11'd0);
    churn(5);
    quiesce();
    set_cap(11'd1);
    churn(5);
    quiesce();
    set_cap(11'd37);
    calm = 1'b1;
    churn(15);
    calm = 1'b0;
    quiesce();
    set_cap(11'd2047);
    send_chunk(65, 0);
    churn(5);
    quiesce();
    set_cap(11'd5);
    churn(5);
    quiesce();
    set_cap(11'd1024);
    churn(5);

    in_ch.valid <= 1'b0;
    while (ring.due() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (ring.errors == 0 && ring.due() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
